/* sv/utf8sf_pkg.sv */
// shared types and constants of the utf-8 sequence filter
package utf8sf_pkg;

  // byte classes
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] Lead2Mask   = 8'hE0;
  localparam logic [7:0] Lead2Code   = 8'hC0;
  localparam logic [7:0] Lead3Mask   = 8'hF0;
  localparam logic [7:0] Lead3Code   = 8'hE0;
  localparam logic [7:0] Lead4Mask   = 8'hF8;
  localparam logic [7:0] Lead4Code   = 8'hF0;
  localparam logic [1:0] ContTag     = 2'b10;

  // sequence lengths, none means no open sequence
  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned HeldDepth  = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_done;
  } result_t;

endpackage

/* sv/utf8_sequence_filter_core.sv */
// utf-8 sequence filter top level: sequence tracking and result burst buffer
//
// Takes a byte stream one item per cycle and passes on only well-formed
// utf-8 sequences. Ascii bytes pass at once; a lead byte opens a 2, 3 or
// 4 byte sequence that is held and released whole on its final byte, and
// only if every following byte was a continuation byte. Stray continuation
// bytes and bytes 0xF8 and above in lead position are dropped. An item with
// text_end_i high closes the text: an unfinished sequence is discarded and
// the last result carries text_done_o, or a single end-only result (no byte)
// is given. Each item yields 0 to 4 results, all computed in the cycle the
// item is accepted and loaded into a four-entry burst register that drains
// one result per cycle while out_ready_i is high. An input item is accepted
// whenever the burst register is empty or is giving up its last result in
// the same cycle, so items that make at most one result flow at one per
// cycle; an item that releases an n-byte sequence holds the input while
// the burst drains. No clearing pass after reset.
module utf8_sequence_filter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  // sequence state
  logic [2:0] seq_len_q, seq_len_d;
  logic [1:0] seq_cnt_q, seq_cnt_d;
  logic       seq_ok_q,  seq_ok_d;
  logic [7:0] held_q [utf8sf_pkg::HeldDepth];
  logic [7:0] held_d [utf8sf_pkg::HeldDepth];

  // burst buffer, entry 0 is on the output
  utf8sf_pkg::result_t burst_q [utf8sf_pkg::MaxResults];
  utf8sf_pkg::result_t burst_d [utf8sf_pkg::MaxResults];
  logic [2:0] burst_cnt_q, burst_cnt_d;

  // results of the item on the input
  utf8sf_pkg::result_t res [utf8sf_pkg::MaxResults];
  logic [7:0] res_byte [utf8sf_pkg::MaxResults];
  logic [2:0] res_n;
  logic       in_acc, out_acc;
  logic       ok_next, seq_full;

  assign out_valid_o = (burst_cnt_q != 3'd0);
  assign out_acc     = out_valid_o & out_ready_i;
  // free when empty, or when the last waiting result leaves now
  assign in_ready_o  = (burst_cnt_q == 3'd0) | ((burst_cnt_q == 3'd1) & out_ready_i);
  assign in_acc      = in_valid_i & in_ready_o;

  assign out_byte_o  = burst_q[0].out_byte;
  assign has_byte_o  = burst_q[0].has_byte;
  assign run_last_o  = burst_q[0].run_last;
  assign text_done_o = burst_q[0].text_done;

  assign ok_next  = seq_ok_q & (in_byte_i[7:6] == utf8sf_pkg::ContTag);
  assign seq_full = ({1'b0, seq_cnt_q} + 3'd1) >= seq_len_q;

  // sequence tracking and result list for the incoming item
  always_comb begin
    seq_len_d = seq_len_q;
    seq_cnt_d = seq_cnt_q;
    seq_ok_d  = seq_ok_q;
    held_d    = held_q;
    res_n     = 3'd0;
    for (int k = 0; k < utf8sf_pkg::MaxResults; k++) begin
      res_byte[k] = in_byte_i;
    end

    if (seq_len_q == utf8sf_pkg::SeqNone) begin
      if (in_byte_i < utf8sf_pkg::AsciiLimit) begin
        res_n = 3'd1;
      end else begin
        // lead byte decode, anything else in lead position is dropped
        priority if ((in_byte_i & utf8sf_pkg::Lead2Mask) == utf8sf_pkg::Lead2Code) begin
          seq_len_d = utf8sf_pkg::SeqLen2;
        end else if ((in_byte_i & utf8sf_pkg::Lead3Mask) == utf8sf_pkg::Lead3Code) begin
          seq_len_d = utf8sf_pkg::SeqLen3;
        end else if ((in_byte_i & utf8sf_pkg::Lead4Mask) == utf8sf_pkg::Lead4Code) begin
          seq_len_d = utf8sf_pkg::SeqLen4;
        end else begin
          seq_len_d = utf8sf_pkg::SeqNone;
        end
        if (seq_len_d != utf8sf_pkg::SeqNone) begin
          held_d[0] = in_byte_i;
          seq_cnt_d = 2'd1;
          seq_ok_d  = 1'b1;
        end
      end
    end else if (seq_full) begin
      // final byte: release held bytes then this one, if all were good
      if (ok_next) begin
        res_n = {1'b0, seq_cnt_q} + 3'd1;
        for (int k = 0; k < utf8sf_pkg::HeldDepth; k++) begin
          if (2'(k) < seq_cnt_q) begin
            res_byte[k] = held_q[k];
          end
        end
      end
      seq_len_d = utf8sf_pkg::SeqNone;
      seq_cnt_d = 2'd0;
      seq_ok_d  = 1'b1;
    end else begin
      held_d[seq_cnt_q] = in_byte_i;
      seq_cnt_d = seq_cnt_q + 2'd1;
      seq_ok_d  = ok_next;
    end

    // end of text closes any open sequence
    if (text_end_i) begin
      seq_len_d = utf8sf_pkg::SeqNone;
      seq_cnt_d = 2'd0;
      seq_ok_d  = 1'b1;
    end

    for (int k = 0; k < utf8sf_pkg::MaxResults; k++) begin
      res[k].out_byte  = res_byte[k];
      res[k].has_byte  = 1'b1;
      res[k].run_last  = (3'(k) == res_n - 3'd1);
      res[k].text_done = text_end_i & (3'(k) == res_n - 3'd1);
    end
    // end-only result
    if (text_end_i && res_n == 3'd0) begin
      res_n           = 3'd1;
      res[0].out_byte = 8'h00;
      res[0].has_byte = 1'b0;
      res[0].run_last = 1'b1;
      res[0].text_done = 1'b1;
    end
  end

  // burst buffer: load on item accept, else shift on result accept
  always_comb begin
    burst_d     = burst_q;
    burst_cnt_d = burst_cnt_q;
    if (in_acc) begin
      burst_d     = res;
      burst_cnt_d = res_n;
    end else if (out_acc) begin
      for (int k = 0; k < utf8sf_pkg::MaxResults - 1; k++) begin
        burst_d[k] = burst_q[k + 1];
      end
      burst_cnt_d = burst_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q   <= utf8sf_pkg::SeqNone;
      seq_cnt_q   <= 2'd0;
      seq_ok_q    <= 1'b1;
      burst_cnt_q <= 3'd0;
    end else begin
      if (in_acc) begin
        seq_len_q <= seq_len_d;
        seq_cnt_q <= seq_cnt_d;
        seq_ok_q  <= seq_ok_d;
      end
      burst_cnt_q <= burst_cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_q <= held_d;
    end
    burst_q <= burst_d;
  end

endmodule
